### rtl/vgrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrt_pkg
// Shared types and constants for the voxel grid ray traversal block.
// ----------------------------------------------------------------------------
package vgrt_pkg;

  // Sequencer states of the traversal engine.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_CHECK
  } state_t;

  // Operation codes of a command transaction.
  localparam logic OP_CAST  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Entry face codes.
  localparam logic [2:0] FACE_LOW_X  = 3'd0;
  localparam logic [2:0] FACE_HIGH_X = 3'd1;
  localparam logic [2:0] FACE_LOW_Y  = 3'd2;
  localparam logic [2:0] FACE_HIGH_Y = 3'd3;
  localparam logic [2:0] FACE_LOW_Z  = 3'd4;
  localparam logic [2:0] FACE_HIGH_Z = 3'd5;
  localparam logic [2:0] FACE_NONE   = 3'd6;

  // Ray parameter values: saturated, and a value above any saturated one.
  localparam logic [33:0] T_SAT   = 34'h0_FFFF_FFFF;
  localparam logic [33:0] T_NEVER = 34'h2_0000_0000;

  localparam logic [9:0] MAX_STEPS_RESET = 10'd100;

endpackage

### rtl/vgrt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrt interfaces
// Command, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface vgrt_cmd_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [17:0] dir_z;
  logic [15:0]        cell_x;
  logic [15:0]        cell_y;
  logic [15:0]        cell_z;
  logic [31:0]        write_word;

  modport source (output valid, operation, origin_x, origin_y, origin_z, dir_x, dir_y,
                  dir_z, cell_x, cell_y, cell_z, write_word, input ready);
  modport sink (input valid, operation, origin_x, origin_y, origin_z, dir_x, dir_y,
                dir_z, cell_x, cell_y, cell_z, write_word, output ready);
endinterface

interface vgrt_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [15:0] hit_x;
  logic signed [15:0] hit_y;
  logic signed [15:0] hit_z;
  logic [2:0]         entry_face;
  logic [31:0]        hit_word;

  modport source (output valid, hit, hit_x, hit_y, hit_z, entry_face, hit_word,
                  input ready);
  modport sink (input valid, hit, hit_x, hit_y, hit_z, entry_face, hit_word,
                output ready);
endinterface

interface vgrt_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] max_steps;

  modport source (output valid, max_steps, input ready);
  modport sink (input valid, max_steps, output ready);
endinterface

### rtl/voxel_grid_ray_traversal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal
// Voxel store with a fixed-point DDA ray walker built on a shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per item. A write stores one voxel word when
//   accepted and gives no response; writes outside the grid are dropped.
//   A cast walks a ray through the grid and gives one response on rsp.
//   cfg writes max_steps at any cycle; it is meant to change only when idle.
// Sequence of a cast: the command is accepted in idle, then six divisions
//   run on one restoring divider, then each voxel lookup takes a step state
//   (step and memory read) and a check state, for up to max_steps+1 lookups.
//   cmd.ready is low throughout a cast.
// Reset: after rst the memory is cleared by a pass over all GRID_DIM^3 words
//   (262144 at the default size), one word per cycle, with cmd.ready low.
//   max_steps returns to 100.
// Stalls: the response is held in an output register until rsp.ready. A new
//   command can be accepted while it waits; a cast that finishes before the
//   previous response is taken waits in its check state.
// ----------------------------------------------------------------------------
module voxel_grid_ray_traversal
  import vgrt_pkg::*;
#(
  parameter int GRID_DIM = 64
) (
  input  logic        clk,
  input  logic        rst,
  vgrt_cfg_if.sink    cfg,
  vgrt_cmd_if.sink    cmd,
  vgrt_rsp_if.source  rsp
);

  localparam int DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROW_MUL   = AW'(GRID_DIM);
  localparam logic [AW-1:0] PLANE_MUL = AW'(GRID_DIM * GRID_DIM);
  localparam logic [15:0]   DIM16     = 16'(GRID_DIM);

  state_t state, state_next;

  // Configuration register.
  logic [9:0] max_steps;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_steps <= MAX_STEPS_RESET;
    end else if (cfg.valid) begin
      max_steps <= cfg.max_steps;
    end
  end

  // Per-axis ray state.
  logic signed [15:0] pos [3];
  logic [33:0]        tmax [3];
  logic [33:0]        tdel [3];
  logic [16:0]        left [3];
  logic [17:0]        adir [3];
  logic               dneg [3];
  logic               dzero [3];
  logic [9:0]         n;
  logic [2:0]         face;

  // Shared divider.
  logic [2:0]  div_sel;
  logic [5:0]  div_cnt;
  logic [32:0] dq;
  logic [17:0] rem;
  logic [18:0] rem_sh;
  logic        q_bit;
  logic [17:0] rem_new;
  logic [32:0] q_final;
  logic [33:0] q_sat;
  logic [1:0]  div_axis;
  logic [2:0]  next_sel;
  logic [32:0] next_num;

  // Memory.
  logic [31:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          rd_ok;

  // Output register.
  logic               rsp_valid;
  logic               out_hit;
  logic signed [15:0] out_x, out_y, out_z;
  logic [2:0]         out_face;
  logic [31:0]        out_word;

  // Distance to the first boundary in Q0.16.
  function automatic logic [16:0] first_left(input logic [15:0] frac,
                                             input logic [17:0] d);
    logic [16:0] r;
    if (!d[17] && d != 18'd0) begin
      r = (frac != 16'd0) ? (17'h10000 - {1'b0, frac}) : 17'd0;
    end else begin
      r = {1'b0, frac};
    end
    return r;
  endfunction

  function automatic logic [17:0] abs18(input logic [17:0] d);
    return d[17] ? (18'd0 - d) : d;
  endfunction

  logic cmd_fire;
  assign cmd_fire = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE);

  // One restoring divider iteration.
  assign div_axis = div_sel[2:1];
  assign rem_sh   = {rem, dq[32]};
  assign q_bit    = (rem_sh >= {1'b0, adir[div_axis]});
  assign rem_new  = q_bit ? 18'(rem_sh - {1'b0, adir[div_axis]}) : rem_sh[17:0];
  assign q_final  = {dq[31:0], q_bit};
  assign q_sat    = q_final[32] ? T_SAT : {1'b0, q_final};
  assign next_sel = div_sel + 3'd1;
  assign next_num = next_sel[0] ? 33'h1_0000_0000 : {left[next_sel[2:1]], 16'h0000};

  // Step choice: X only when strictly least, Y when below Z and not above X, else Z.
  logic       any_dir;
  logic       x_lt_y, x_lt_z, y_lt_z;
  logic [1:0] step_axis;
  logic [34:0] t_sum;
  logic [33:0] t_adv;
  logic signed [15:0] nc [3];
  logic       in_grid;

  assign any_dir = !(dzero[0] && dzero[1] && dzero[2]);
  assign x_lt_y  = tmax[0] < tmax[1];
  assign x_lt_z  = tmax[0] < tmax[2];
  assign y_lt_z  = tmax[1] < tmax[2];

  always_comb begin
    if (x_lt_y && x_lt_z) begin
      step_axis = 2'd0;
    end else if (!x_lt_y && y_lt_z) begin
      step_axis = 2'd1;
    end else begin
      step_axis = 2'd2;
    end
  end

  assign t_sum = {1'b0, tmax[step_axis]} + {1'b0, tdel[step_axis]};
  assign t_adv = (t_sum > {1'b0, T_SAT}) ? T_SAT : t_sum[33:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nc[i] = pos[i];
      if (any_dir && step_axis == 2'(i)) begin
        nc[i] = dneg[i] ? pos[i] - 16'sd1 : pos[i] + 16'sd1;
      end
    end
  end

  assign in_grid = ($unsigned(nc[0]) < DIM16) && ($unsigned(nc[1]) < DIM16) &&
                   ($unsigned(nc[2]) < DIM16);
  assign rd_addr = AW'($unsigned(nc[2])) * PLANE_MUL + AW'($unsigned(nc[1])) * ROW_MUL
                   + AW'($unsigned(nc[0]));

  // Lookup result and end condition.
  logic [31:0] val;
  logic        finish;
  logic        out_free;
  assign val      = rd_ok ? rd_data : 32'd0;
  assign finish   = (val != 32'd0) || (n >= max_steps);
  assign out_free = !rsp_valid || rsp.ready;

  // Memory write port: clearing pass or write transaction.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 32'd0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (cmd_fire && cmd.operation == OP_WRITE) begin
      mem_we    = (cmd.cell_x < DIM16) && (cmd.cell_y < DIM16) && (cmd.cell_z < DIM16);
      mem_waddr = AW'(cmd.cell_z) * PLANE_MUL + AW'(cmd.cell_y) * ROW_MUL + AW'(cmd.cell_x);
      mem_wdata = cmd.write_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == ST_STEP) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_fire && cmd.operation == OP_CAST) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == 6'd32 && div_sel == 3'd5) state_next = ST_STEP;
      end
      ST_STEP: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!finish) begin
          state_next = ST_STEP;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Ray set-up, divider and stepping datapath.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_fire && cmd.operation == OP_CAST) begin
      pos[0]   <= cmd.origin_x[31:16];
      pos[1]   <= cmd.origin_y[31:16];
      pos[2]   <= cmd.origin_z[31:16];
      left[0]  <= first_left(cmd.origin_x[15:0], cmd.dir_x);
      left[1]  <= first_left(cmd.origin_y[15:0], cmd.dir_y);
      left[2]  <= first_left(cmd.origin_z[15:0], cmd.dir_z);
      adir[0]  <= abs18(cmd.dir_x);
      adir[1]  <= abs18(cmd.dir_y);
      adir[2]  <= abs18(cmd.dir_z);
      dneg[0]  <= cmd.dir_x[17];
      dneg[1]  <= cmd.dir_y[17];
      dneg[2]  <= cmd.dir_z[17];
      dzero[0] <= (cmd.dir_x == 18'sd0);
      dzero[1] <= (cmd.dir_y == 18'sd0);
      dzero[2] <= (cmd.dir_z == 18'sd0);
      div_sel  <= 3'd0;
      div_cnt  <= 6'd0;
      rem      <= 18'd0;
      dq       <= {first_left(cmd.origin_x[15:0], cmd.dir_x), 16'h0000};
      n        <= 10'd0;
      face     <= FACE_NONE;
    end else if (state == ST_DIV) begin
      if (div_cnt == 6'd32) begin
        if (div_sel[0]) begin
          tdel[div_axis] <= dzero[div_axis] ? 34'd0 : q_sat;
        end else begin
          tmax[div_axis] <= dzero[div_axis] ? T_NEVER : q_sat;
        end
        div_sel <= next_sel;
        div_cnt <= 6'd0;
        rem     <= 18'd0;
        dq      <= next_num;
      end else begin
        div_cnt <= div_cnt + 6'd1;
        rem     <= rem_new;
        dq      <= q_final;
      end
    end else if (state == ST_STEP) begin
      rd_ok <= in_grid;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= nc[i];
      end
      if (any_dir) begin
        tmax[step_axis] <= t_adv;
        case (step_axis)
          2'd0:    face <= dneg[0] ? FACE_HIGH_X : FACE_LOW_X;
          2'd1:    face <= dneg[1] ? FACE_HIGH_Y : FACE_LOW_Y;
          default: face <= dneg[2] ? FACE_HIGH_Z : FACE_LOW_Z;
        endcase
      end
    end else if (state == ST_CHECK && !finish) begin
      n <= n + 10'd1;
    end
  end

  // Response register.
  logic load_out;
  assign load_out = (state == ST_CHECK) && finish && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit  <= (val != 32'd0);
      out_x    <= pos[0];
      out_y    <= pos[1];
      out_z    <= pos[2];
      out_face <= face;
      out_word <= val;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = out_hit;
  assign rsp.hit_x      = out_x;
  assign rsp.hit_y      = out_y;
  assign rsp.hit_z      = out_z;
  assign rsp.entry_face = out_face;
  assign rsp.hit_word   = out_word;

endmodule

### rtl/vgrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgrt_checker
// Port-level assertions for the voxel grid ray traversal block.
// ----------------------------------------------------------------------------
module vgrt_checker
  import vgrt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        hit,
  input logic [2:0]  entry_face,
  input logic [31:0] hit_word
);

  // A stalled response transaction stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its word and hit flag.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(hit_word) && $stable(hit))
    else $error("response changed while stalled");

  // A hit always carries a nonzero word, a miss a zero word.
  a_hit_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (hit == (hit_word != 32'd0)))
    else $error("hit flag disagrees with word");

  // The entry face is one of the seven codes.
  a_face: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_face <= FACE_NONE)
    else $error("entry face out of range");

endmodule

bind voxel_grid_ray_traversal vgrt_checker u_vgrt_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .hit        (rsp.hit),
  .entry_face (rsp.entry_face),
  .hit_word   (rsp.hit_word)
);
